// ===== hdl/fpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared constants and types for the frustum point cull core.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Fixed-point format of matrix elements and point coordinates.
    localparam int FRAC_BITS   = 16;
    localparam int PLANE_COUNT = 6;

    localparam int COORD_W  = 32;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int ADDR_W   = 4;
    localparam int COL_W    = 2;
    localparam int ROW_W    = 2;
    localparam int PLANE_W  = 3;

    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANE_COUNT - 1);
    localparam logic [COL_W-1:0]   LAST_COL   = '1;
    localparam logic [ROW_W-1:0]   W_ROW      = '1;

    // Operand used for the constant term so that it lands on the product scale.
    localparam logic signed [COORD_W-1:0] ONE_Q = COORD_W'(64'sd1 <<< FRAC_BITS);

    // Request kinds carried on the input tuser.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    // Tag that follows one plane term through the shared datapath.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic             plus;
        logic             first;
        logic             last;
    } t_term_tag;

    // Status returned by the datapath once all planes are done.
    typedef struct packed {
        logic done;
        logic in_view;
    } t_unit_status;

endpackage
`default_nettype wire

// ===== hdl/fpc_plane_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpc_plane_unit
// Matrix store and the shared plane datapath: coefficient, multiply, and
// saturating accumulate, one plane term per beat of the sequencer.
// ----------------------------------------------------------------------------
module fpc_plane_unit
    import fpc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_wr_en,
    input  wire logic [ADDR_W-1:0]         i_wr_addr,
    input  wire logic signed [COORD_W-1:0] i_wr_data,
    input  wire t_term_tag                 i_issue,
    input  wire logic [ROW_W-1:0]          i_row,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic signed [COORD_W-1:0] i_point_z,
    output t_unit_status                   o_status
);

    logic signed [COORD_W-1:0] r_mem [16];
    logic signed [COORD_W-1:0] r_w;
    logic signed [COORD_W-1:0] r_e;
    logic signed [COORD_W-1:0] r_coef;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_acc;
    t_term_tag                 r_t1;
    t_term_tag                 r_t2;
    t_term_tag                 r_t3;
    logic                      r_fail;
    logic                      r_done;
    logic                      r_inside;

    logic signed [COORD_W:0]   w_csum;
    logic signed [COORD_W-1:0] w_coef;
    logic signed [COORD_W-1:0] w_opnd;
    logic signed [PROD_W-1:0]  w_base;
    logic signed [PROD_W:0]    w_asum;
    logic signed [PROD_W-1:0]  w_acc;
    logic                      w_fail_base;
    logic                      w_plane_out;
    logic                      w_fail;

    // Matrix store, written by load beats and read at two addresses per term.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_w <= r_mem[{i_issue.col, W_ROW}];
        r_e <= r_mem[{i_issue.col, i_row}];
    end

    // Coefficient is the w row plus or minus the selected row, clipped to 32 bits.
    always_comb begin
        if (r_t1.plus) begin
            w_csum = {r_w[COORD_W-1], r_w} + {r_e[COORD_W-1], r_e};
        end else begin
            w_csum = {r_w[COORD_W-1], r_w} - {r_e[COORD_W-1], r_e};
        end
        if (w_csum[COORD_W] != w_csum[COORD_W-1]) begin
            w_coef = w_csum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            w_coef = w_csum[COORD_W-1:0];
        end
    end

    always_comb begin
        case (r_t2.col)
            2'd0:    w_opnd = i_point_x;
            2'd1:    w_opnd = i_point_y;
            2'd2:    w_opnd = i_point_z;
            default: w_opnd = ONE_Q;
        endcase
    end

    // Saturating accumulate; the first column starts a fresh plane sum.
    always_comb begin
        w_base = (r_t3.col == '0) ? '0 : r_acc;
        w_asum = {w_base[PROD_W-1], w_base} + {r_prod[PROD_W-1], r_prod};
        if (w_asum[PROD_W] != w_asum[PROD_W-1]) begin
            w_acc = w_asum[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}}
                                   : {1'b0, {(PROD_W-1){1'b1}}};
        end else begin
            w_acc = w_asum[PROD_W-1:0];
        end
        w_fail_base = r_t3.first ? 1'b0 : r_fail;
        w_plane_out = (r_t3.col == LAST_COL) && (w_acc[PROD_W-1] || (w_acc == '0));
        w_fail      = w_fail_base || w_plane_out;
    end

    always_ff @(posedge i_clk) begin
        r_coef <= w_coef;
        r_prod <= PROD_W'(r_coef) * PROD_W'(w_opnd);
        if (r_t3.valid) begin
            r_acc <= w_acc;
        end
        r_inside <= !w_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_t3   <= '0;
            r_fail <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_t1   <= i_issue;
            r_t2   <= r_t1;
            r_t3   <= r_t2;
            r_done <= r_t3.valid && r_t3.last;
            if (r_t3.valid) begin
                r_fail <= w_fail;
            end
        end
    end

    assign o_status.done    = r_done;
    assign o_status.in_view = r_inside;

endmodule
`default_nettype wire

// ===== hdl/frustum_point_cull_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_point_cull_core
// View-frustum point test against the six planes of a stored matrix.
// ----------------------------------------------------------------------------
// A load beat writes one matrix element; it gives no result.
// After a test beat the core takes no new beat until the result has gone to
// the output register, which waits while the previous result is not taken.
// The walk runs six planes times four columns through the single shared
// multiplier, followed by the four stages of the datapath.
// Synchronous active-low reset clears the control state; the matrix is not
// cleared and must be loaded before any test reads it.
// ----------------------------------------------------------------------------
module frustum_point_cull_core
    import fpc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: elem_index[3:0], elem_value[35:4], point_x[67:36],
    //        point_y[99:68], point_z[131:100], zero pad[135:132]
    input  wire logic [135:0] s_axis_tdata,
    // tuser: req_type[0]
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: inside_res[0], zero pad[7:1]
    output logic [7:0]        m_axis_tdata
);

    // Control runs through three one-hot states: idle and taking beats, walking
    // the planes, and holding a finished result until the output is free.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_issuing;
    logic [PLANE_W-1:0]        r_plane;
    logic [COL_W-1:0]          r_col;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_pz;
    logic                      r_m_valid;
    logic                      n_m_valid;
    logic                      r_m_inside;
    logic                      n_m_inside;
    logic                      r_pend;
    logic                      n_pend;

    logic         w_accept;
    logic         w_load;
    logic         w_test;
    logic         w_out_free;
    t_term_tag    w_issue;
    t_unit_status w_status;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_accept && (s_axis_tuser == REQ_LOAD);
    assign w_test        = w_accept && (s_axis_tuser == REQ_TEST);
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // The sequencer walks plane by plane, column by column, one term per cycle.
    // Even planes add the selected row to the w row, odd planes subtract it.
    always_comb begin
        w_issue.valid = r_issuing;
        w_issue.col   = r_col;
        w_issue.plus  = !r_plane[0];
        w_issue.first = (r_plane == '0) && (r_col == '0);
        w_issue.last  = (r_plane == LAST_PLANE) && (r_col == LAST_COL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_plane   <= '0;
            r_col     <= '0;
        end else if (w_test) begin
            r_issuing <= 1'b1;
            r_plane   <= '0;
            r_col     <= '0;
        end else if (r_issuing) begin
            r_col <= r_col + 1'b1;
            if (r_col == LAST_COL) begin
                r_plane <= r_plane + 1'b1;
            end
            if (w_issue.last) begin
                r_issuing <= 1'b0;
            end
        end
    end

    // The point is held for the whole walk; the datapath picks one coordinate
    // per term, or the constant one for the last column.
    always_ff @(posedge i_clk) begin
        if (w_test) begin
            r_px <= s_axis_tdata[67:36];
            r_py <= s_axis_tdata[99:68];
            r_pz <= s_axis_tdata[131:100];
        end
    end

    fpc_plane_unit u_plane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_load),
        .i_wr_addr (s_axis_tdata[3:0]),
        .i_wr_data (s_axis_tdata[35:4]),
        .i_issue   (w_issue),
        .i_row     (r_plane[2:1]),
        .i_point_x (r_px),
        .i_point_y (r_py),
        .i_point_z (r_pz),
        .o_status  (w_status)
    );

    // A finished result goes straight to the output register when it is free,
    // otherwise it is parked until the downstream side takes the previous beat.
    always_comb begin
        n_state    = r_state;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_inside = r_m_inside;
        n_pend     = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (w_test) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_status.done) begin
                    if (w_out_free) begin
                        n_m_valid  = 1'b1;
                        n_m_inside = w_status.in_view;
                        n_state    = S_IDLE;
                    end else begin
                        n_pend  = w_status.in_view;
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (w_out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_inside = r_pend;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_inside <= n_m_inside;
        r_pend     <= n_pend;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'b0, r_m_inside};

    // The datapath only reports completion while a test walk is in progress.
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |-> (r_state == S_RUN))
        else $error("plane unit finished outside a test walk");

    // Terms are issued only while the walk is active.
    a_issue_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (r_state == S_RUN))
        else $error("term issued while not running");

    // An accepted test starts issuing terms at the very next cycle.
    a_test_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_test |=> (r_issuing && (r_plane == '0) && (r_col == '0)))
        else $error("test beat did not start the plane walk");

    // A parked result never coexists with an empty output register.
    a_wait_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> r_m_valid)
        else $error("result parked while output register was free");

endmodule
`default_nettype wire

// ===== dv/frustum_cull_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_checker
// Watches both stream channels of the cull core and checks every inside flag.
// ----------------------------------------------------------------------------
module frustum_cull_checker
    import fpc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_req_valid,
    input  wire logic         i_req_ready,
    // Request fields from the lowest bit up: elem_index, elem_value,
    // point_x, point_y, point_z.
    input  wire logic [135:0] i_req_data,
    input  wire logic         i_req_kind,
    input  wire logic         i_res_valid,
    input  wire logic         i_res_ready,
    input  wire logic [7:0]   i_res_data,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_results_seen,
    output int                o_inside_seen
);

    localparam longint COEF_MAX = 64'sd2147483647;
    localparam longint COEF_MIN = -64'sd2147483648;
    localparam longint ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN  = 64'sh8000_0000_0000_0000;

    // Local copy of the view-projection matrix, column-major.
    logic signed [COORD_W-1:0] cull_matrix [16];
    // Inside flags owed by the core, oldest first.
    logic inside_due [$];

    int mismatches   = 0;
    int pending_cnt  = 0;
    int results_seen = 0;
    int inside_seen  = 0;

    assign o_mismatches   = mismatches;
    assign o_pending      = pending_cnt;
    assign o_results_seen = results_seen;
    assign o_inside_seen  = inside_seen;

    // Plane coefficient: row 3 plus or minus the chosen row, clamped to 32 bits.
    function automatic longint plane_coef(int col, int row, bit plus);
        longint w;
        longint e;
        longint s;
        w = longint'(cull_matrix[col * 4 + 3]);
        e = longint'(cull_matrix[col * 4 + row]);
        s = plus ? w + e : w - e;
        if (s > COEF_MAX) begin
            s = COEF_MAX;
        end else if (s < COEF_MIN) begin
            s = COEF_MIN;
        end
        return s;
    endfunction

    function automatic longint acc_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? ACC_MIN : ACC_MAX;
        end
        return s[63:0];
    endfunction

    // True only when the point lies strictly on the positive side of all planes.
    function automatic logic frustum_contains(longint px, longint py, longint pz);
        longint acc;
        int     row;
        bit     plus;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            row  = p / 2;
            plus = (p % 2) == 0;
            acc  = plane_coef(0, row, plus) * px;
            acc  = acc_add(acc, plane_coef(1, row, plus) * py);
            acc  = acc_add(acc, plane_coef(2, row, plus) * pz);
            acc  = acc_add(acc, plane_coef(3, row, plus) * (64'sd1 <<< FRAC_BITS));
            if (acc <= 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic want;
        logic got;
        if (i_rst_n) begin
            // Results are handled first; a test accepted on this edge can
            // never be the one answered on the same edge.
            if (i_res_valid && i_res_ready) begin
                got          = i_res_data[0];
                results_seen = results_seen + 1;
                if (got) begin
                    inside_seen = inside_seen + 1;
                end
                if (inside_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: result beat with nothing owed, expected none, actual %0b",
                             $time, got);
                end else begin
                    want = inside_due.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                                 $time, want, got);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_kind == REQ_LOAD) begin
                    cull_matrix[i_req_data[3:0]] = i_req_data[35:4];
                end else begin
                    inside_due.push_back(frustum_contains(
                        longint'($signed(i_req_data[67:36])),
                        longint'($signed(i_req_data[99:68])),
                        longint'($signed(i_req_data[131:100]))));
                end
            end
            pending_cnt = inside_due.size();
        end
    end

endmodule

// ===== dv/frustum_point_cull_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_point_cull_core_tb
// Stimulus and verdict for the frustum point cull core.
// ----------------------------------------------------------------------------
// Loads matrices element by element and sends point tests, first a short
// directed set around the plane boundaries and the saturation limits, then
// random traffic with idle bursts on both channels. A separate checker
// predicts every inside flag and counts mismatches.
// ----------------------------------------------------------------------------
module frustum_point_cull_core_tb;
    import fpc_pkg::*;

    localparam int ITEM_TARGET = 950;
    localparam int QUIET_FROM  = 850;
    localparam int DRAIN_AT    = 475;
    // Covers the tail of the last test after the results drain.
    localparam int TAIL_CYCLES = 40;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_NEAR_ONE = 32'h0000_FFFF;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: elem_index[3:0], elem_value[35:4], point_x[67:36],
    //        point_y[99:68], point_z[131:100], zero pad[135:132]
    logic [135:0] s_axis_tdata;
    // tuser: req_type[0]
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: inside_res[0], zero pad[7:1]
    logic [7:0]   m_axis_tdata;

    int mismatches;
    int pending;
    int results_seen;
    int inside_seen;

    // Idle bursts on both channels are allowed only while this is set.
    bit idle_on = 1'b1;
    int loads_sent = 0;
    int tests_sent = 0;

    frustum_point_cull_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    frustum_cull_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_axis_tvalid),
        .i_req_ready    (s_axis_tready),
        .i_req_data     (s_axis_tdata),
        .i_req_kind     (s_axis_tuser),
        .i_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .i_res_data     (m_axis_tdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_inside_seen  (inside_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("frustum_point_cull_core test failed");
        $finish;
    end

    // Result side: holds tready low for random bursts while idling is allowed.
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left    = stall_left - 1;
                m_axis_tready = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left    = $urandom_range(1, 13) - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Presents one beat at a falling edge, possibly after an idle burst, and
    // returns at the rising edge where it is accepted.
    task automatic push_request(logic kind, logic [3:0] idx, logic [31:0] val,
                                logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tdata  = {4'b0, pz, py, px, val, idx};
        s_axis_tuser  = kind;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == REQ_LOAD) begin
            loads_sent = loads_sent + 1;
        end else begin
            tests_sent = tests_sent + 1;
        end
    endtask

    // Loads carry random point fields and tests random element fields, since
    // the core is meant to ignore them.
    task automatic load_elem(logic [3:0] idx, logic [31:0] val);
        push_request(REQ_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic test_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        push_request(REQ_TEST, 4'($urandom), $urandom, px, py, pz);
    endtask

    // Mostly values within two units of the origin, so both outcomes are
    // common; the rest spans the full range and its edges.
    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return 32'($urandom_range(0, 262144)) - 32'd131072;
        end else if (sel < 9) begin
            return $urandom;
        end
        case ($urandom_range(0, 4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return 32'h1;
        endcase
    endfunction

    // A well-formed matrix has positive scales on the diagonal, a positive
    // w term and small cross terms; otherwise every element is arbitrary.
    task automatic load_matrix(bit well_formed);
        logic [31:0] val;
        for (int i = 0; i < 16; i++) begin
            if (!well_formed) begin
                val = pick_coord();
            end else if (i == 15) begin
                val = 32'($urandom_range(32768, 131072));
            end else if (i == 0 || i == 5 || i == 10) begin
                val = 32'($urandom_range(16384, 131072));
            end else begin
                val = 32'($urandom_range(0, 16384)) - 32'd8192;
            end
            load_elem(4'(i), val);
        end
    endtask

    task automatic wait_results_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int items;
        bit drained;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Identity matrix: the frustum is the open cube of half-width one.
        for (int i = 0; i < 16; i++) begin
            load_elem(4'(i), (i % 5 == 0) ? Q_ONE : 32'h0);
        end
        test_point(32'h0, 32'h0, 32'h0);
        // Exactly on the right and left planes gives a zero plane value.
        test_point(Q_ONE, 32'h0, 32'h0);
        test_point(-Q_ONE, 32'h0, 32'h0);
        test_point(Q_NEAR_ONE, -Q_NEAR_ONE, Q_NEAR_ONE);
        test_point(Q_MAX, Q_MAX, Q_MAX);
        test_point(Q_MIN, Q_MIN, Q_MIN);
        // Full-scale elements saturate the coefficients, and with full-scale
        // points the plane sums hit the accumulator limits.
        load_elem(4'd3, Q_MAX);
        load_elem(4'd0, Q_MAX);
        load_elem(4'd7, Q_MAX);
        test_point(Q_MAX, Q_MAX, 32'h0);
        test_point(Q_MIN, Q_MIN, 32'h0);
        load_elem(4'd7, Q_MIN);
        test_point(Q_MAX, Q_MIN, Q_MIN);

        // Random traffic. The first reload covers every element again, so no
        // test ever reads an element that was never loaded.
        load_matrix(1'b1);
        items   = loads_sent + tests_sent;
        drained = 1'b0;
        while (items < ITEM_TARGET) begin
            if (items >= QUIET_FROM) begin
                idle_on = 1'b0;
            end else if (items % 64 == 0) begin
                idle_on = $urandom_range(0, 3) != 0;
            end
            if (!drained && items >= DRAIN_AT) begin
                // Hold the sender until the core has nothing outstanding.
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                wait_results_drained();
                drained = 1'b1;
            end
            case ($urandom_range(0, 31))
                0, 1: load_matrix(1'b1);
                2:    load_matrix(1'b0);
                3, 4, 5, 6, 7, 8, 9: load_elem(4'($urandom), pick_coord());
                default: test_point(pick_coord(), pick_coord(), pick_coord());
            endcase
            items = loads_sent + tests_sent;
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d element loads and %0d point tests.", loads_sent, tests_sent);
        $display("Checked %0d results: %0d inside, %0d outside.",
                 results_seen, inside_seen, results_seen - inside_seen);
        if (mismatches == 0) begin
            $display("frustum_point_cull_core test passed");
        end else begin
            $display("frustum_point_cull_core test failed");
        end
        $finish;
    end

endmodule

// ===== frustum_point_cull_core.f =====
hdl/fpc_pkg.sv
hdl/fpc_plane_unit.sv
hdl/frustum_point_cull_core.sv
dv/frustum_cull_checker.sv
dv/frustum_point_cull_core_tb.sv
